// ----- design/fpf_pkg.sv -----
// Shared types, constants and arithmetic helpers for the polarization force block.
// No dependencies; imported by every other file of the block.
package fpf_pkg;

  localparam int VAL_W = 64;
  localparam int PROD_W = 2 * VAL_W;
  localparam int HALF_W = VAL_W / 2;
  localparam int FRAC_SHIFT = 24;
  localparam int OUT_W = 48;
  localparam int COEF_W = 32;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam int NSTG = 16;
  localparam int DATA_WIDTH_DEF = 32;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t LIM_MAG = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [VAL_W:0] LIM_WIDE = 65'sh0_3FFF_FFFF_FFFF_FFFF;
  localparam val_t OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam val_t OUT_MIN = -64'sh0000_8000_0000_0000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_B1_B2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B3_A1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A11_A12 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A111_A112 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A1111_A1112 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A1122 = 3'd5;

  // Coefficients already scaled to 24 fraction bits and multiplied by their constant.
  typedef struct packed {
    val_t b1;
    val_t b2;
    val_t b3;
    val_t a1_x2;
    val_t a11_x4;
    val_t a12_x2;
    val_t a111_x6;
    val_t a112_x4;
    val_t a112_x2;
    val_t a1111_x8;
    val_t a1112_x6;
    val_t a1112_x2;
    val_t a1122_x4;
  } coef_t;

  typedef struct packed {
    val_t val;
    logic sat;
  } sq_t;

  // Q16.16 coefficient to a 24 fraction bit value.
  function automatic val_t coef_q24(input logic [COEF_W-1:0] c);
    val_t r;
    r = {{(VAL_W-COEF_W-8){c[COEF_W-1]}}, c, 8'b0};
    return r;
  endfunction

  // Sum with clamping to the intermediate magnitude limit.
  function automatic sq_t add_q(input val_t a, input val_t b);
    logic signed [VAL_W:0] sum;
    sq_t r;
    sum = (VAL_W+1)'(a) + (VAL_W+1)'(b);
    r.sat = 1'b0;
    r.val = sum[VAL_W-1:0];
    if (sum > LIM_WIDE) begin
      r.val = LIM_MAG;
      r.sat = 1'b1;
    end else if (sum < -LIM_WIDE) begin
      r.val = -LIM_MAG;
      r.sat = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- design/fpf_cfg.sv -----
// Coefficient register file with pre-scaling of each coefficient by its constant.
// Depends on fpf_pkg.
module fpf_cfg import fpf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output coef_t                coef
);

  logic [CFG_W-1:0]  b1_b2_r, b3_a1_r, a11_a12_r, a111_a112_r, a1111_a1112_r;
  logic [COEF_W-1:0] a1122_r;
  val_t a112_q, a1112_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_b2_r       <= '0;
      b3_a1_r       <= '0;
      a11_a12_r     <= '0;
      a111_a112_r   <= '0;
      a1111_a1112_r <= '0;
      a1122_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_B1_B2:       b1_b2_r       <= cfg_data;
        REG_B3_A1:       b3_a1_r       <= cfg_data;
        REG_A11_A12:     a11_a12_r     <= cfg_data;
        REG_A111_A112:   a111_a112_r   <= cfg_data;
        REG_A1111_A1112: a1111_a1112_r <= cfg_data;
        REG_A1122:       a1122_r       <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign a112_q  = coef_q24(a111_a112_r[COEF_W-1:0]);
  assign a1112_q = coef_q24(a1111_a1112_r[COEF_W-1:0]);

  always_comb begin
    coef.b1       = coef_q24(b1_b2_r[CFG_W-1:COEF_W]);
    coef.b2       = coef_q24(b1_b2_r[COEF_W-1:0]);
    coef.b3       = coef_q24(b3_a1_r[CFG_W-1:COEF_W]);
    coef.a1_x2    = coef_q24(b3_a1_r[COEF_W-1:0]) <<< 1;
    coef.a11_x4   = coef_q24(a11_a12_r[CFG_W-1:COEF_W]) <<< 2;
    coef.a12_x2   = coef_q24(a11_a12_r[COEF_W-1:0]) <<< 1;
    coef.a111_x6  = (coef_q24(a111_a112_r[CFG_W-1:COEF_W]) <<< 1)
                  + (coef_q24(a111_a112_r[CFG_W-1:COEF_W]) <<< 2);
    coef.a112_x4  = a112_q <<< 2;
    coef.a112_x2  = a112_q <<< 1;
    coef.a1111_x8 = coef_q24(a1111_a1112_r[CFG_W-1:COEF_W]) <<< 3;
    coef.a1112_x6 = (a1112_q <<< 1) + (a1112_q <<< 2);
    coef.a1112_x2 = a1112_q <<< 1;
    coef.a1122_x4 = coef_q24(a1122_r) <<< 2;
  end

endmodule

// ----- design/fpf_mul.sv -----
// Two-stage saturating fixed-point multiplier (24 fraction bits, truncation toward zero).
// Depends on fpf_pkg.
module fpf_mul import fpf_pkg::*; (
  input  logic clk,
  input  logic en_a,
  input  logic en_b,
  input  val_t a,
  input  val_t b,
  output val_t prod,
  output logic ovf
);

  logic [VAL_W-1:0]  mag_a, mag_b, mag_res;
  logic [VAL_W-1:0]  pp00_r, pp01_r, pp10_r, pp11_r;
  logic              neg_r, ovf_nxt, ovf_r;
  logic [PROD_W-1:0] full;
  val_t              prod_nxt, prod_r;

  assign mag_a = a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
  assign mag_b = b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b);

  // First stage: four 32x32 partial products of the magnitudes.
  always_ff @(posedge clk) begin
    if (en_a) begin
      pp00_r <= VAL_W'(mag_a[HALF_W-1:0]) * VAL_W'(mag_b[HALF_W-1:0]);
      pp01_r <= VAL_W'(mag_a[HALF_W-1:0]) * VAL_W'(mag_b[VAL_W-1:HALF_W]);
      pp10_r <= VAL_W'(mag_a[VAL_W-1:HALF_W]) * VAL_W'(mag_b[HALF_W-1:0]);
      pp11_r <= VAL_W'(mag_a[VAL_W-1:HALF_W]) * VAL_W'(mag_b[VAL_W-1:HALF_W]);
      neg_r  <= a[VAL_W-1] ^ b[VAL_W-1];
    end
  end

  // Second stage: sum, drop the fraction bits, clamp and restore the sign.
  always_comb begin
    full = PROD_W'(pp00_r) + (PROD_W'(pp01_r) << HALF_W) + (PROD_W'(pp10_r) << HALF_W)
         + (PROD_W'(pp11_r) << VAL_W);
    ovf_nxt = |full[PROD_W-1:VAL_W+FRAC_SHIFT-2];
    mag_res = ovf_nxt ? VAL_W'(LIM_MAG) : {2'b00, full[VAL_W+FRAC_SHIFT-3:FRAC_SHIFT]};
    prod_nxt = neg_r ? -$signed(mag_res) : $signed(mag_res);
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      prod_r <= prod_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign prod = prod_r;
  assign ovf  = ovf_r;

endmodule

// ----- design/ferro_polarization_force.sv -----
// Top level of the ferroelectric polarization driving force pipeline.
// Depends on fpf_pkg, fpf_cfg and fpf_mul.
//
// Usage
//   Each request on the input channel (in_valid / in_ready) carries one
//   integration point: the component selector, both polarization components,
//   four strain entries, the field component, the degradation factor and the
//   impermeable flag. Each request yields exactly one result on the output
//   channel (out_valid / out_ready): the driving force in Q24.24, clamped to
//   48 bits, and a flag that is set when any step saturated.
//   The coefficients are written through the cfg_ port while the pipeline is
//   empty; they are read directly by the multiplier levels.
//   One request is taken every cycle while the receiver takes results. The
//   depth is set by the chain of five dependent multiplies (each registers
//   32x32 partial products, then sums and clamps) and the in-order clamped
//   accumulation of the Landau terms.
//   Reset (synchronous, rst_n low) empties the pipeline and clears all
//   coefficients to zero. When the receiver stalls, a stage holds only while
//   it and every stage after it are full, so empty slots close up and
//   requests are still taken until every stage holds an item.
module ferro_polarization_force import fpf_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd,
  input  logic signed [DATA_WIDTH-1:0] in_polar_x,
  input  logic signed [DATA_WIDTH-1:0] in_polar_y,
  input  logic signed [DATA_WIDTH-1:0] in_strain_xx,
  input  logic signed [DATA_WIDTH-1:0] in_strain_yy,
  input  logic signed [DATA_WIDTH-1:0] in_strain_xy,
  input  logic signed [DATA_WIDTH-1:0] in_strain_yx,
  input  logic signed [DATA_WIDTH-1:0] in_field_comp,
  input  logic [DATA_WIDTH-2:0]        in_degradation,
  input  logic                         in_impermeable,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OUT_W-1:0]      out_force_res,
  output logic                         out_saturated
);

  coef_t coef;

  fpf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // Stage occupancy and load enables. A stage loads when it is empty or
  // when every stage behind it down to the output can move.
  logic [NSTG-1:0] v_r, v_nxt, ld;

  genvar gk;
  generate
    for (gk = 0; gk < NSTG; gk++) begin : g_ld
      assign ld[gk] = out_ready | ~&v_r[NSTG-1:gk];
    end
  endgenerate

  always_comb begin
    v_nxt = v_r;
    for (int k = 0; k < NSTG; k++) begin
      if (ld[k]) begin
        v_nxt[k] = (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[NSTG-1];

  // Stage 0: capture, select the driven component and its partner.
  val_t p0_s_r, p0_o_r, p0_es_r, p0_eo_r, p0_sh_r, p0_ef_r, p0_dg_r;
  logic p0_imp_r;
  val_t px_w, py_w, exx_w, eyy_w;

  assign px_w  = VAL_W'(in_polar_x);
  assign py_w  = VAL_W'(in_polar_y);
  assign exx_w = VAL_W'(in_strain_xx);
  assign eyy_w = VAL_W'(in_strain_yy);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      p0_s_r   <= in_cmd ? py_w : px_w;
      p0_o_r   <= in_cmd ? px_w : py_w;
      p0_es_r  <= in_cmd ? eyy_w : exx_w;
      p0_eo_r  <= in_cmd ? exx_w : eyy_w;
      p0_sh_r  <= VAL_W'(in_strain_xy) + VAL_W'(in_strain_yx);
      p0_ef_r  <= VAL_W'(in_field_comp);
      p0_dg_r  <= $signed(VAL_W'(in_degradation));
      p0_imp_r <= in_impermeable;
    end
  end

  // Multiplier levels.
  val_t m1_a [5], m1_b [5], m1_p [5];
  val_t m2_a [7], m2_b [7], m2_p [7];
  val_t m3_a [7], m3_b [7], m3_p [7];
  val_t m4_a [8], m4_b [8], m4_p [8];
  val_t m5_a [3], m5_b [3], m5_p [3];
  logic [4:0] m1_s;
  logic [6:0] m2_s, m3_s;
  logic [7:0] m4_s;
  logic [2:0] m5_s;

  generate
    for (gk = 0; gk < 5; gk++) begin : g_m1
      fpf_mul u_mul (.clk(clk), .en_a(ld[1]), .en_b(ld[2]), .a(m1_a[gk]), .b(m1_b[gk]),
                     .prod(m1_p[gk]), .ovf(m1_s[gk]));
    end
    for (gk = 0; gk < 7; gk++) begin : g_m2
      fpf_mul u_mul (.clk(clk), .en_a(ld[3]), .en_b(ld[4]), .a(m2_a[gk]), .b(m2_b[gk]),
                     .prod(m2_p[gk]), .ovf(m2_s[gk]));
    end
    for (gk = 0; gk < 7; gk++) begin : g_m3
      fpf_mul u_mul (.clk(clk), .en_a(ld[6]), .en_b(ld[7]), .a(m3_a[gk]), .b(m3_b[gk]),
                     .prod(m3_p[gk]), .ovf(m3_s[gk]));
    end
    for (gk = 0; gk < 8; gk++) begin : g_m4
      fpf_mul u_mul (.clk(clk), .en_a(ld[9]), .en_b(ld[10]), .a(m4_a[gk]), .b(m4_b[gk]),
                     .prod(m4_p[gk]), .ovf(m4_s[gk]));
    end
    for (gk = 0; gk < 3; gk++) begin : g_m5
      fpf_mul u_mul (.clk(clk), .en_a(ld[11]), .en_b(ld[12]), .a(m5_a[gk]), .b(m5_b[gk]),
                     .prod(m5_p[gk]), .ovf(m5_s[gk]));
    end
  endgenerate

  // Level one: s^2, o^2 and the three strain products.
  assign m1_a[0] = p0_s_r;  assign m1_b[0] = p0_s_r;
  assign m1_a[1] = p0_o_r;  assign m1_b[1] = p0_o_r;
  assign m1_a[2] = p0_es_r; assign m1_b[2] = p0_s_r;
  assign m1_a[3] = p0_eo_r; assign m1_b[3] = p0_s_r;
  assign m1_a[4] = p0_sh_r; assign m1_b[4] = p0_o_r;

  // Stages 1 and 2 carry what level two needs.
  val_t p1_s_r, p1_o_r, p1_ef_r, p1_dg_r, p2_s_r, p2_o_r, p2_ef_r, p2_dg_r;
  logic p1_imp_r, p2_imp_r;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      p1_s_r <= p0_s_r; p1_o_r <= p0_o_r; p1_ef_r <= p0_ef_r;
      p1_dg_r <= p0_dg_r; p1_imp_r <= p0_imp_r;
    end
    if (ld[2]) begin
      p2_s_r <= p1_s_r; p2_o_r <= p1_o_r; p2_ef_r <= p1_ef_r;
      p2_dg_r <= p1_dg_r; p2_imp_r <= p1_imp_r;
    end
  end

  // Level two: s^3, o^4, s*o^2, the coupling terms and the quadratic Landau term.
  assign m2_a[0] = m1_p[0];  assign m2_b[0] = p2_s_r;
  assign m2_a[1] = m1_p[1];  assign m2_b[1] = m1_p[1];
  assign m2_a[2] = p2_s_r;   assign m2_b[2] = m1_p[1];
  assign m2_a[3] = coef.b1;  assign m2_b[3] = m1_p[2];
  assign m2_a[4] = coef.b2;  assign m2_b[4] = m1_p[3];
  assign m2_a[5] = coef.b3;  assign m2_b[5] = m1_p[4];
  assign m2_a[6] = coef.a1_x2; assign m2_b[6] = p2_s_r;

  val_t p3_s_r, p3_s2_r, p3_o2_r, p3_ef_r, p3_dg_r;
  val_t p4_s_r, p4_s2_r, p4_o2_r, p4_ef_r, p4_dg_r;
  logic p3_imp_r, p3_sat_r, p4_imp_r, p4_sat_r;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      p3_s_r <= p2_s_r; p3_s2_r <= m1_p[0]; p3_o2_r <= m1_p[1];
      p3_ef_r <= p2_ef_r; p3_dg_r <= p2_dg_r; p3_imp_r <= p2_imp_r;
      p3_sat_r <= |m1_s;
    end
    if (ld[4]) begin
      p4_s_r <= p3_s_r; p4_s2_r <= p3_s2_r; p4_o2_r <= p3_o2_r;
      p4_ef_r <= p3_ef_r; p4_dg_r <= p3_dg_r; p4_imp_r <= p3_imp_r;
      p4_sat_r <= p3_sat_r;
    end
  end

  // Stage 5: sum the coupling terms in order.
  sq_t cp_a, cp_b;
  val_t p5_s_r, p5_s2_r, p5_s3_r, p5_o2_r, p5_o4_r, p5_so2_r, p5_t1_r, p5_t_r;
  val_t p5_ef_r, p5_dg_r;
  logic p5_imp_r, p5_sat_r;

  assign cp_a = add_q(m2_p[3], m2_p[4]);
  assign cp_b = add_q(cp_a.val, m2_p[5]);

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      p5_s_r <= p4_s_r; p5_s2_r <= p4_s2_r; p5_s3_r <= m2_p[0];
      p5_o2_r <= p4_o2_r; p5_o4_r <= m2_p[1]; p5_so2_r <= m2_p[2];
      p5_t1_r <= m2_p[6]; p5_t_r <= cp_b.val;
      p5_ef_r <= p4_ef_r; p5_dg_r <= p4_dg_r; p5_imp_r <= p4_imp_r;
      p5_sat_r <= p4_sat_r | (|m2_s) | cp_a.sat | cp_b.sat;
    end
  end

  // Level three: s^5, o^6, mixed powers and the quartic terms.
  assign m3_a[0] = p5_s3_r;     assign m3_b[0] = p5_s2_r;
  assign m3_a[1] = p5_o4_r;     assign m3_b[1] = p5_o2_r;
  assign m3_a[2] = p5_s3_r;     assign m3_b[2] = p5_o2_r;
  assign m3_a[3] = p5_s_r;      assign m3_b[3] = p5_o4_r;
  assign m3_a[4] = p5_s3_r;     assign m3_b[4] = p5_o4_r;
  assign m3_a[5] = coef.a11_x4; assign m3_b[5] = p5_s3_r;
  assign m3_a[6] = coef.a12_x2; assign m3_b[6] = p5_so2_r;

  // Stage 6: operand of the degradation product. With an impermeable point
  // the field is taken inside the degraded part.
  sq_t xe;
  val_t p6_s_r, p6_s2_r, p6_o2_r, p6_t1_r, p6_dg_r, p6_ef_r, p6_x_r;
  val_t p7_s_r, p7_s2_r, p7_o2_r, p7_t1_r, p7_dg_r, p7_ef_r, p7_x_r;
  logic p6_imp_r, p6_sat_r, p7_imp_r, p7_sat_r;

  assign xe = add_q(-p5_t_r, -p5_ef_r);

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      p6_s_r <= p5_s_r; p6_s2_r <= p5_s2_r; p6_o2_r <= p5_o2_r;
      p6_t1_r <= p5_t1_r; p6_dg_r <= p5_dg_r; p6_ef_r <= p5_ef_r;
      p6_imp_r <= p5_imp_r;
      p6_x_r <= p5_imp_r ? xe.val : -p5_t_r;
      p6_sat_r <= p5_sat_r | (p5_imp_r & xe.sat);
    end
    if (ld[7]) begin
      p7_s_r <= p6_s_r; p7_s2_r <= p6_s2_r; p7_o2_r <= p6_o2_r;
      p7_t1_r <= p6_t1_r; p7_dg_r <= p6_dg_r; p7_ef_r <= p6_ef_r;
      p7_imp_r <= p6_imp_r; p7_x_r <= p6_x_r; p7_sat_r <= p6_sat_r;
    end
  end

  // Stage 8: first three Landau terms, in order.
  sq_t l8_a, l8_b;
  val_t p8_s_r, p8_s2_r, p8_o2_r, p8_s5_r, p8_o6_r, p8_s3o2_r, p8_so4_r, p8_s3o4_r;
  val_t p8_dg_r, p8_x_r, p8_ef_r, p8_acc_r;
  logic p8_imp_r, p8_sat_r;

  assign l8_a = add_q(p7_t1_r, m3_p[5]);
  assign l8_b = add_q(l8_a.val, m3_p[6]);

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      p8_s_r <= p7_s_r; p8_s2_r <= p7_s2_r; p8_o2_r <= p7_o2_r;
      p8_s5_r <= m3_p[0]; p8_o6_r <= m3_p[1]; p8_s3o2_r <= m3_p[2];
      p8_so4_r <= m3_p[3]; p8_s3o4_r <= m3_p[4];
      p8_dg_r <= p7_dg_r; p8_x_r <= p7_x_r; p8_ef_r <= p7_ef_r;
      p8_imp_r <= p7_imp_r; p8_acc_r <= l8_b.val;
      p8_sat_r <= p7_sat_r | (|m3_s) | l8_a.sat | l8_b.sat;
    end
  end

  // Level four: s^7, the sixth-order and mixed eighth-order terms, degradation product.
  assign m4_a[0] = p8_s5_r;      assign m4_b[0] = p8_s2_r;
  assign m4_a[1] = p8_s5_r;      assign m4_b[1] = p8_o2_r;
  assign m4_a[2] = p8_s_r;       assign m4_b[2] = p8_o6_r;
  assign m4_a[3] = coef.a111_x6; assign m4_b[3] = p8_s5_r;
  assign m4_a[4] = coef.a112_x4; assign m4_b[4] = p8_s3o2_r;
  assign m4_a[5] = coef.a112_x2; assign m4_b[5] = p8_so4_r;
  assign m4_a[6] = coef.a1122_x4; assign m4_b[6] = p8_s3o4_r;
  assign m4_a[7] = p8_dg_r;      assign m4_b[7] = p8_x_r;

  val_t p9_acc_r, p9_ef_r, p10_acc_r, p10_ef_r;
  logic p9_imp_r, p9_sat_r, p10_imp_r, p10_sat_r;

  always_ff @(posedge clk) begin
    if (ld[9]) begin
      p9_acc_r <= p8_acc_r; p9_ef_r <= p8_ef_r;
      p9_imp_r <= p8_imp_r; p9_sat_r <= p8_sat_r;
    end
    if (ld[10]) begin
      p10_acc_r <= p9_acc_r; p10_ef_r <= p9_ef_r;
      p10_imp_r <= p9_imp_r; p10_sat_r <= p9_sat_r;
    end
  end

  // Level five: the eighth-order terms.
  assign m5_a[0] = coef.a1111_x8; assign m5_b[0] = m4_p[0];
  assign m5_a[1] = coef.a1112_x6; assign m5_b[1] = m4_p[1];
  assign m5_a[2] = coef.a1112_x2; assign m5_b[2] = m4_p[2];

  // Stages 11 to 14: the rest of the Landau sum, strictly left to right.
  sq_t l11_a, l11_b, l12_a, l13_a, l13_b, l14_a, l14_b;
  val_t p11_acc_r, p11_t6_r, p11_t10_r, p11_m_r, p11_ef_r;
  val_t p12_acc_r, p12_t10_r, p12_m_r, p12_ef_r;
  val_t p13_acc_r, p13_t9_r, p13_t10_r, p13_m_r, p13_ef_r;
  val_t p14_dchi_r, p14_m_r, p14_ef_r;
  logic p11_imp_r, p11_sat_r, p12_imp_r, p12_sat_r;
  logic p13_imp_r, p13_sat_r, p14_imp_r, p14_sat_r;

  assign l11_a = add_q(p10_acc_r, m4_p[3]);
  assign l11_b = add_q(l11_a.val, m4_p[4]);
  assign l12_a = add_q(p11_acc_r, p11_t6_r);
  assign l13_a = add_q(p12_acc_r, m5_p[0]);
  assign l13_b = add_q(l13_a.val, m5_p[1]);
  assign l14_a = add_q(p13_acc_r, p13_t9_r);
  assign l14_b = add_q(l14_a.val, p13_t10_r);

  always_ff @(posedge clk) begin
    if (ld[11]) begin
      p11_acc_r <= l11_b.val; p11_t6_r <= m4_p[5]; p11_t10_r <= m4_p[6];
      p11_m_r <= m4_p[7]; p11_ef_r <= p10_ef_r; p11_imp_r <= p10_imp_r;
      p11_sat_r <= p10_sat_r | (|m4_s) | l11_a.sat | l11_b.sat;
    end
    if (ld[12]) begin
      p12_acc_r <= l12_a.val; p12_t10_r <= p11_t10_r; p12_m_r <= p11_m_r;
      p12_ef_r <= p11_ef_r; p12_imp_r <= p11_imp_r;
      p12_sat_r <= p11_sat_r | l12_a.sat;
    end
    if (ld[13]) begin
      p13_acc_r <= l13_b.val; p13_t9_r <= m5_p[2]; p13_t10_r <= p12_t10_r;
      p13_m_r <= p12_m_r; p13_ef_r <= p12_ef_r; p13_imp_r <= p12_imp_r;
      p13_sat_r <= p12_sat_r | (|m5_s) | l13_a.sat | l13_b.sat;
    end
    if (ld[14]) begin
      p14_dchi_r <= l14_b.val; p14_m_r <= p13_m_r; p14_ef_r <= p13_ef_r;
      p14_imp_r <= p13_imp_r;
      p14_sat_r <= p13_sat_r | l14_a.sat | l14_b.sat;
    end
  end

  // Stage 15: combine field, Landau and degraded coupling, clamp to 48 bits.
  sq_t f_a, f_b, f_i;
  val_t f_sum;
  logic f_sat;
  logic signed [OUT_W-1:0] out_force_res_r;
  logic out_saturated_r;

  assign f_a = add_q(p14_ef_r, -p14_dchi_r);
  assign f_b = add_q(f_a.val, -p14_m_r);
  assign f_i = add_q(-p14_m_r, -p14_dchi_r);

  always_comb begin
    if (p14_imp_r) begin
      f_sum = f_i.val;
      f_sat = p14_sat_r | f_i.sat;
    end else begin
      f_sum = f_b.val;
      f_sat = p14_sat_r | f_a.sat | f_b.sat;
    end
    if (f_sum > OUT_MAX) begin
      f_sum = OUT_MAX;
      f_sat = 1'b1;
    end else if (f_sum < OUT_MIN) begin
      f_sum = OUT_MIN;
      f_sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[15]) begin
      out_force_res_r <= f_sum[OUT_W-1:0];
      out_saturated_r <= f_sat;
    end
  end

  assign out_force_res = out_force_res_r;
  assign out_saturated = out_saturated_r;

`ifndef ASSERT_OFF
  // Input back-pressure only ever comes from a stalled receiver.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled full output");

  // An item in the last inner stage that moves on must appear at the output.
  a_last_move: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NSTG-2] && ld[NSTG-1]) |=> out_valid)
    else $error("item lost between the final stages");

  // Reset leaves the pipeline empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");
`endif

endmodule

// ----- test/tb_ferro_polarization_force.sv -----
// Self-checking testbench for the ferroelectric polarization force pipeline.
// Depends on fpf_pkg and ferro_polarization_force; predicts each result in-line.
`timescale 1ns / 1ps

module tb_ferro_polarization_force import fpf_pkg::*;;

  localparam int DW = 32;
  localparam longint MAG_LIMIT = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint FORCE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint FORCE_MIN = -64'sh0000_8000_0000_0000;

  typedef struct packed {
    logic          cmd;
    logic [DW-1:0] px;
    logic [DW-1:0] py;
    logic [DW-1:0] exx;
    logic [DW-1:0] eyy;
    logic [DW-1:0] exy;
    logic [DW-1:0] eyx;
    logic [DW-1:0] ef;
    logic [DW-2:0] dg;
    logic          imp;
  } point_t;

  typedef struct packed {
    logic [OUT_W-1:0] force_val;
    logic             sat;
  } force_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  point_t pt = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_force_res;
  logic out_saturated;

  // Local copy of the coefficient registers, written alongside the block.
  logic [CFG_W-1:0] coef_regs [0:5];
  force_t force_queue [$];
  int errors = 0;
  // Probability (in percent) that the receiver stalls; changed per phase.
  int stall_pct = 20;

  always #1 clk = ~clk;

  ferro_polarization_force #(.DATA_WIDTH(DW)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(pt.cmd), .in_polar_x(pt.px), .in_polar_y(pt.py),
    .in_strain_xx(pt.exx), .in_strain_yy(pt.eyy),
    .in_strain_xy(pt.exy), .in_strain_yx(pt.eyx),
    .in_field_comp(pt.ef), .in_degradation(pt.dg), .in_impermeable(pt.imp),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_force_res(out_force_res), .out_saturated(out_saturated)
  );

  // Intermediate clamp to magnitude 2^62-1, remembering that it happened.
  function automatic longint clamp62(input logic signed [65:0] v, inout bit sat);
    if (v > MAG_LIMIT) begin
      sat = 1'b1;
      return MAG_LIMIT;
    end
    if (v < -MAG_LIMIT) begin
      sat = 1'b1;
      return -MAG_LIMIT;
    end
    return longint'(v);
  endfunction

  function automatic longint sum62(input longint a, input longint b, inout bit sat);
    return clamp62(66'(a) + 66'(b), sat);
  endfunction

  // Fixed-point product: magnitude truncated toward zero after the shift by 24.
  function automatic longint prod62(input longint a, input longint b, inout bit sat);
    logic [127:0] mag;
    logic [127:0] shifted;
    logic [63:0] ua;
    logic [63:0] ub;
    longint r;
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    mag = 128'(ua) * 128'(ub);
    shifted = mag >> 24;
    if (shifted > 128'(MAG_LIMIT)) begin
      sat = 1'b1;
      r = MAG_LIMIT;
    end else begin
      r = longint'(shifted[63:0]);
    end
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // A Q16.16 coefficient brought to 24 fraction bits and scaled by k.
  function automatic longint scaled_coef(input logic [31:0] c, input int k);
    return longint'($signed(c)) * longint'(k * 256);
  endfunction

  function automatic force_t predict_force(input point_t p);
    bit sat;
    longint px, py, s, o, es, eo, exy, eyx, ef, dg;
    longint s2, s3, s5, s7, o2, o4, o6, t, dw, dchi, f;
    force_t r;
    sat = 1'b0;
    px = longint'($signed(p.px));
    py = longint'($signed(p.py));
    exy = longint'($signed(p.exy));
    eyx = longint'($signed(p.eyx));
    ef = longint'($signed(p.ef));
    dg = longint'(p.dg);
    s = p.cmd ? py : px;
    o = p.cmd ? px : py;
    es = p.cmd ? longint'($signed(p.eyy)) : longint'($signed(p.exx));
    eo = p.cmd ? longint'($signed(p.exx)) : longint'($signed(p.eyy));

    // Electrostrictive part.
    t = prod62(scaled_coef(coef_regs[0][63:32], 1), prod62(es, s, sat), sat);
    t = sum62(t, prod62(scaled_coef(coef_regs[0][31:0], 1), prod62(eo, s, sat), sat), sat);
    t = sum62(t, prod62(scaled_coef(coef_regs[1][63:32], 1),
                        prod62(exy + eyx, o, sat), sat), sat);
    dw = -t;

    s2 = prod62(s, s, sat);
    s3 = prod62(s2, s, sat);
    s5 = prod62(s3, s2, sat);
    s7 = prod62(s5, s2, sat);
    o2 = prod62(o, o, sat);
    o4 = prod62(o2, o2, sat);
    o6 = prod62(o4, o2, sat);

    // Landau part, accumulated in a fixed order with clamping at every step.
    dchi = prod62(scaled_coef(coef_regs[1][31:0], 2), s, sat);
    dchi = sum62(dchi, prod62(scaled_coef(coef_regs[2][63:32], 4), s3, sat), sat);
    dchi = sum62(dchi, prod62(scaled_coef(coef_regs[2][31:0], 2),
                              prod62(s, o2, sat), sat), sat);
    dchi = sum62(dchi, prod62(scaled_coef(coef_regs[3][63:32], 6), s5, sat), sat);
    dchi = sum62(dchi, prod62(scaled_coef(coef_regs[3][31:0], 4),
                              prod62(s3, o2, sat), sat), sat);
    dchi = sum62(dchi, prod62(scaled_coef(coef_regs[3][31:0], 2),
                              prod62(s, o4, sat), sat), sat);
    dchi = sum62(dchi, prod62(scaled_coef(coef_regs[4][63:32], 8), s7, sat), sat);
    dchi = sum62(dchi, prod62(scaled_coef(coef_regs[4][31:0], 6),
                              prod62(s5, o2, sat), sat), sat);
    dchi = sum62(dchi, prod62(scaled_coef(coef_regs[4][31:0], 2),
                              prod62(s, o6, sat), sat), sat);
    dchi = sum62(dchi, prod62(scaled_coef(coef_regs[5][31:0], 4),
                              prod62(s3, o4, sat), sat), sat);

    // The impermeable flag decides whether the field is degraded with the coupling.
    if (!p.imp) begin
      f = sum62(ef, -dchi, sat);
      f = sum62(f, -prod62(dg, dw, sat), sat);
    end else begin
      f = -prod62(dg, sum62(dw, -ef, sat), sat);
      f = sum62(f, -dchi, sat);
    end

    if (f > FORCE_MAX) begin
      f = FORCE_MAX;
      sat = 1'b1;
    end else if (f < FORCE_MIN) begin
      f = FORCE_MIN;
      sat = 1'b1;
    end
    r.force_val = f[OUT_W-1:0];
    r.sat = sat;
    return r;
  endfunction

  // Random gap: mostly none or short, occasionally long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; valid from the previous request is only dropped
  // when a gap follows, so back-to-back requests keep it high.
  task automatic send_point(input point_t p);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    pt <= p;
    in_valid <= 1'b1;
    force_queue.push_back(predict_force(p));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_A1122) coef_regs[5] = {32'b0, val[31:0]};
    else coef_regs[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every expected result has come back, then allow the pipeline depth.
  task automatic drain();
    in_valid <= 1'b0;
    while (force_queue.size() != 0) @(negedge clk);
    repeat (NSTG + 4) @(negedge clk);
  endtask

  // Receiver: random stalls, and the check of each accepted result.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if ($urandom_range(0, 99) < stall_pct) out_ready <= 1'b0;
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    force_t want;
    if (rst_n && out_valid && out_ready) begin
      if (force_queue.size() == 0) begin
        $display("%0t: unexpected result force=%h sat=%b", $time,
                 out_force_res, out_saturated);
        errors++;
      end else begin
        want = force_queue.pop_front();
        if (out_force_res !== want.force_val) begin
          $display("%0t: force mismatch expected %h actual %h", $time,
                   want.force_val, out_force_res);
          errors++;
        end
        if (out_saturated !== want.sat) begin
          $display("%0t: saturated mismatch expected %b actual %b", $time,
                   want.sat, out_saturated);
          errors++;
        end
      end
    end
  end

  function automatic logic [DW-1:0] pick_val();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4, 5: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic point_t random_point();
    point_t p;
    p.cmd = 1'($urandom_range(0, 1));
    p.px = pick_val();
    p.py = pick_val();
    p.exx = pick_val();
    p.eyy = pick_val();
    p.exy = pick_val();
    p.eyx = pick_val();
    p.ef = pick_val();
    p.dg = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0100_0000));
    p.imp = 1'($urandom_range(0, 1));
    return p;
  endfunction

  function automatic logic [31:0] random_coef();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  task automatic load_coefs(input bit extreme_hi, input bit extreme_lo, input bit rnd);
    logic [31:0] c [0:10];
    for (int i = 0; i < 11; i++) begin
      if (rnd) c[i] = random_coef();
      else if (extreme_hi) c[i] = 32'h7FFF_FFFF;
      else if (extreme_lo) c[i] = 32'h8000_0000;
      else c[i] = 32'h0001_0000 + 32'(i) * 32'h0000_4000;
    end
    write_coef(REG_B1_B2, {c[0], c[1]});
    write_coef(REG_B3_A1, {c[2], c[3]});
    write_coef(REG_A11_A12, {c[4], c[5]});
    write_coef(REG_A111_A112, {c[6], c[7]});
    write_coef(REG_A1111_A1112, {c[8], c[9]});
    write_coef(REG_A1122, {$urandom, c[10]});
  endtask

  // Directed points: zero coefficients first, then unit-like coefficients, with
  // field extremes, both components, both impermeable modes and full-scale inputs.
  task automatic test_directed();
    point_t p;
    for (int i = 0; i < 24; i++) begin
      if (i == 12) begin
        drain();
        load_coefs(1'b0, 1'b0, 1'b0);
      end
      p = '0;
      p.cmd = i[0];
      p.imp = i[1];
      case (i % 6)
        0: p = p;
        1: begin
          p.px = 32'h7FFF_FFFF; p.py = 32'h8000_0000; p.ef = 32'h7FFF_FFFF;
          p.exx = 32'h7FFF_FFFF; p.eyy = 32'h8000_0000; p.dg = '1;
        end
        2: begin
          p.px = 32'h0100_0000; p.py = 32'hFF00_0000; p.ef = 32'h8000_0000;
          p.exy = 32'h0080_0000; p.eyx = 32'h0080_0000; p.dg = 31'h0100_0000;
        end
        3: begin
          p.px = 32'h8000_0000; p.py = 32'h8000_0000; p.exy = 32'h8000_0000;
          p.eyx = 32'h8000_0000; p.dg = 31'h7FFF_FFFF;
        end
        4: begin
          p.px = 32'h0180_0000; p.py = 32'h0040_0000; p.exx = 32'h0001_0000;
          p.eyy = 32'hFFFF_0000; p.ef = 32'h0000_0001; p.dg = 31'h0080_0000;
        end
        default: p = random_point();
      endcase
      send_point(p);
    end
    drain();
  endtask

  // Random points across several coefficient settings, including both extremes.
  task automatic test_random(input int count);
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_coefs(1'b1, 1'b0, 1'b0);
        1: load_coefs(1'b0, 1'b1, 1'b0);
        default: load_coefs(1'b0, 1'b0, 1'b1);
      endcase
      // Vary back-pressure: one phase runs without any stall.
      stall_pct = (phase == 3) ? 0 : ((phase == 4) ? 60 : 20);
      for (int n = 0; n < count / 6; n++) send_point(random_point());
      drain();
    end
    // An unused register index must leave the coefficients untouched.
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= 3'd7;
    cfg_data <= '1;
    @(negedge clk);
    cfg_we <= 1'b0;
    for (int n = 0; n < 40; n++) send_point(random_point());
    drain();
  endtask

  initial begin
    for (int i = 0; i < 6; i++) coef_regs[i] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(912);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
